// ----- rtl/flbp_pkg.sv -----
`timescale 1ns / 1ps
package flbp_pkg;

  localparam int POOL_BLOCKS = 1024;
  localparam int BLK_W       = $clog2(POOL_BLOCKS);
  localparam int CNT_W       = BLK_W + 1;

  typedef enum logic [1:0] {
    ACT_GROW   = 2'd0,
    ACT_ALLOC  = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_RETIRE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_CLIPPED = 3'd2,
    ST_REFUSED = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_GROW
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [CNT_W-1:0]   block_count;
    logic               has_block;
    logic [BLK_W-1:0]   block_index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [BLK_W-1:0]   granted_block;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   total_count;
    logic [CNT_W-1:0]   peak_used;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t action;
    logic    grow_zero;
    logic    grow_last;
  } dp_stat_t;

endpackage

// ----- rtl/flbp_ram.sv -----
`timescale 1ns / 1ps
module flbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/flbp_ctrl.sv -----
`timescale 1ns / 1ps
module flbp_ctrl
  import flbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.action == ACT_GROW) begin
          if (stat.grow_zero) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.step = 1'b1;
            if (stat.grow_last) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_GROW;
            end
          end
        end else begin
          // link read issued at capture is back now
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_GROW: begin
        cmd.step = 1'b1;
        if (stat.grow_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_grow_only_in_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW) |-> (stat.action == ACT_GROW && !stat.grow_zero))
    else $error("grow loop running without blocks left");
  a_capture_leads_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_DECIDE))
    else $error("capture not followed by decide");
  a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE))
    else $error("result emitted but controller not idle");
`endif

endmodule

// ----- rtl/flbp_dp.sv -----
`timescale 1ns / 1ps
module flbp_dp
  import flbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_data,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data
);

  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             clip_r, clip_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [CNT_W-1:0] room_c;
  logic [CNT_W-1:0] add_c;
  logic [CNT_W-1:0] used_c;
  logic             alloc_ok, free_ok, retire_ok;

  logic             ram_we;
  logic [BLK_W-1:0] ram_waddr;
  logic [CNT_W-1:0] ram_rdata;

  flbp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (head_r),
    .re    (cmd.capture),
    .raddr (head_r[BLK_W-1:0]),
    .rdata (ram_rdata)
  );

  assign room_c    = CNT_W'(POOL_BLOCKS) - fresh_r;
  assign add_c     = (in_data.block_count < room_c) ? in_data.block_count : room_c;
  assign alloc_ok  = (head_r < CNT_W'(POOL_BLOCKS)) && (free_r != '0);
  assign free_ok   = item_r.has_block && ({1'b0, item_r.block_index} < fresh_r) &&
                     (free_r < total_r);
  assign retire_ok = (free_r == total_r);
  assign used_c    = total_r - free_nxt;

  assign stat.action    = item_r.action;
  assign stat.grow_zero = (left_r == '0);
  assign stat.grow_last = (left_r == CNT_W'(1));

  always_comb begin
    item_nxt      = item_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    total_nxt     = total_r;
    peak_nxt      = peak_r;
    fresh_nxt     = fresh_r;
    left_nxt      = left_r;
    clip_nxt      = clip_r;
    ram_we        = 1'b0;
    ram_waddr     = fresh_r[BLK_W-1:0];

    if (cmd.capture) begin
      item_nxt = in_data;
      left_nxt = add_c;
      clip_nxt = (add_c < in_data.block_count);
    end

    // one never-used block pushed per cycle
    if (cmd.step) begin
      ram_we    = 1'b1;
      head_nxt  = fresh_r;
      fresh_nxt = fresh_r + CNT_W'(1);
      free_nxt  = free_r + CNT_W'(1);
      total_nxt = total_r + CNT_W'(1);
      left_nxt  = left_r - CNT_W'(1);
    end

    if (cmd.commit) begin
      case (item_r.action)
        ACT_ALLOC: begin
          if (alloc_ok) begin
            head_nxt = ram_rdata;
            free_nxt = free_r - CNT_W'(1);
          end
        end
        ACT_FREE: begin
          if (free_ok) begin
            ram_we    = 1'b1;
            ram_waddr = item_r.block_index;
            head_nxt  = {1'b0, item_r.block_index};
            free_nxt  = free_r + CNT_W'(1);
          end
        end
        ACT_RETIRE: begin
          if (retire_ok) begin
            head_nxt  = CNT_W'(POOL_BLOCKS);
            free_nxt  = '0;
            total_nxt = '0;
            fresh_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd.commit && item_r.action == ACT_ALLOC && alloc_ok && peak_r < used_c) begin
      peak_nxt = used_c;
    end
    if (cmd.commit && item_r.action == ACT_RETIRE && retire_ok) begin
      peak_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt         = cmd.emit;
    out_nxt               = out_r;
    if (cmd.emit) begin
      out_nxt.granted_block = '0;
      case (item_r.action)
        ACT_GROW:   out_nxt.status = clip_r ? ST_CLIPPED : ST_OK;
        ACT_ALLOC: begin
          out_nxt.status = alloc_ok ? ST_OK : ST_EMPTY;
          if (alloc_ok) begin
            out_nxt.granted_block = head_r[BLK_W-1:0];
          end
        end
        ACT_FREE:   out_nxt.status = free_ok ? ST_OK : ST_IGNORED;
        ACT_RETIRE: out_nxt.status = retire_ok ? ST_OK : ST_REFUSED;
        default:    out_nxt.status = ST_OK;
      endcase
      out_nxt.free_count  = free_nxt;
      out_nxt.total_count = total_nxt;
      out_nxt.peak_used   = peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= CNT_W'(POOL_BLOCKS);
      free_r      <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      fresh_r     <= '0;
      left_r      <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      peak_r      <= peak_nxt;
      fresh_r     <= fresh_nxt;
      left_r      <= left_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_fresh_tracks_total: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r == total_r)
    else $error("fresh index and total count diverged");
  a_free_within_total: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= total_r)
    else $error("free count above total count");
  a_peak_within_total: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r <= total_r)
    else $error("peak used above total count");
  a_no_back_to_back_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("results on consecutive cycles");
`endif

endmodule

// ----- rtl/free_list_block_pool_core.sv -----
`timescale 1ns / 1ps
// Timing: after accept the controller moves to DECIDE; alloc, free, retire and a grow
// that adds nothing emit there; a grow steps once per added block, one link write each.
// A new word is taken only in IDLE; busy stays high until the link update ends.
// Alloc reads the head's link at accept; the registered link memory read is why DECIDE follows.
// Reset (rst_n low, synchronous): empty pool, all counts zero; link memory is not cleared.
// The result is a one-cycle strobe; the receiver cannot stall.
module free_list_block_pool_core
  import flbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  flbp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  flbp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/pool_result_checker.sv -----
`timescale 1ns / 1ps
module pool_result_checker
  import flbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  // shadow of the pool
  int head;
  int free_n;
  int total_n;
  int peak_n;
  int fresh;
  int link [POOL_BLOCKS];

  out_item_t want_q [$];
  out_item_t oldest;

  function automatic void pool_clear();
    head    = POOL_BLOCKS;
    free_n  = 0;
    total_n = 0;
    peak_n  = 0;
    fresh   = 0;
  endfunction

  function automatic out_item_t pool_apply(in_item_t w);
    out_item_t r;
    int        cnt;
    int        add;
    int        idx;
    r        = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_GROW: begin
        cnt = int'(w.block_count);
        add = (cnt < POOL_BLOCKS - fresh) ? cnt : POOL_BLOCKS - fresh;
        // fresh blocks go onto the head in ascending order
        for (int i = 0; i < add; i++) begin
          link[fresh] = head;
          head        = fresh;
          fresh++;
        end
        free_n  += add;
        total_n += add;
        if (add < cnt) r.status = ST_CLIPPED;
      end
      ACT_ALLOC: begin
        if (head >= POOL_BLOCKS || free_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted_block = head[BLK_W-1:0];
          head            = link[head];
          free_n--;
          if (peak_n < total_n - free_n) peak_n = total_n - free_n;
        end
      end
      ACT_FREE: begin
        idx = int'(w.block_index);
        if (!w.has_block || idx >= fresh || free_n >= total_n) begin
          r.status = ST_IGNORED;
        end else begin
          link[idx] = head;
          head      = idx;
          free_n++;
        end
      end
      default: begin
        if (free_n != total_n) r.status = ST_REFUSED;
        else pool_clear();
      end
    endcase
    r.free_count  = free_n[CNT_W-1:0];
    r.total_count = total_n[CNT_W-1:0];
    r.peak_used   = peak_n[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pool_clear();
      want_q.delete();
    end else begin
      if (out_valid) begin
        if (want_q.size() == 0) begin
          $display("%0t ns: unexpected word: status %0d granted %0d free %0d total %0d peak %0d",
                   $time, out_data.status, out_data.granted_block, out_data.free_count,
                   out_data.total_count, out_data.peak_used);
          fail_count++;
        end else begin
          oldest = want_q.pop_front();
          check_field("status", int'(oldest.status), int'(out_data.status));
          check_field("granted_block", int'(oldest.granted_block),
                      int'(out_data.granted_block));
          check_field("free_count", int'(oldest.free_count), int'(out_data.free_count));
          check_field("total_count", int'(oldest.total_count), int'(out_data.total_count));
          check_field("peak_used", int'(oldest.peak_used), int'(out_data.peak_used));
        end
      end
      // a word accepted now cannot come out on this same edge
      if (start && !busy) want_q.push_back(pool_apply(in_data));
    end
    pending = want_q.size();
  end

endmodule

// ----- tb/tb_free_list_block_pool_core.sv -----
`timescale 1ns / 1ps
module tb_free_list_block_pool_core;
  import flbp_pkg::*;

  // a full grow accepts and emits nothing until all POOL_BLOCKS blocks are linked
  localparam int STALL_LIMIT = 4 * POOL_BLOCKS;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int pending;
  int idle_pct;
  int stall;

  // stimulus-side view: actions in flight and blocks the pool has handed out
  action_t inflight_act [$];
  int      held_blocks [$];

  free_list_block_pool_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  pool_result_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      inflight_act.delete();
      held_blocks.delete();
    end else begin
      if (out_valid && inflight_act.size() > 0) begin
        if (inflight_act[0] == ACT_ALLOC && out_data.status == ST_OK)
          held_blocks.push_back(int'(out_data.granted_block));
        if (inflight_act[0] == ACT_RETIRE && out_data.status == ST_OK)
          held_blocks.delete();
        void'(inflight_act.pop_front());
      end
      if (start && !busy) inflight_act.push_back(in_data.action);
    end
  end

  initial begin
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall = 0;
      else stall++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // fields the action does not use are left random
  task automatic send_word(action_t act, int count, bit has, int idx);
    in_item_t                    w;
    logic [$bits(in_item_t)-1:0] junk;
    junk     = $bits(in_item_t)'($urandom);
    w        = junk;
    w.action = act;
    if (act == ACT_GROW) w.block_count = count[CNT_W-1:0];
    if (act == ACT_FREE) begin
      w.has_block   = has;
      w.block_index = idx[BLK_W-1:0];
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      junk = $bits(in_item_t)'($urandom);
      start   <= 1'b0;
      in_data <= junk;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic rand_items(int n);
    int sent;
    int r;
    int k;
    int cnt;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 14) begin
        k = $urandom_range(0, 99);
        if (k < 70)      cnt = $urandom_range(0, 6);
        else if (k < 90) cnt = $urandom_range(7, 64);
        else if (k < 98) cnt = $urandom_range(0, POOL_BLOCKS);
        else             cnt = POOL_BLOCKS;
        send_word(ACT_GROW, cnt, 1'b0, 0);
        sent++;
      end else if (r < 50) begin
        send_word(ACT_ALLOC, 0, 1'b0, 0);
        sent++;
      end else if (r < 86) begin
        k = $urandom_range(0, 99);
        if (held_blocks.size() > 0 && k < 85) begin
          k = $urandom_range(0, held_blocks.size() - 1);
          cnt = held_blocks[k];
          held_blocks.delete(k);
          send_word(ACT_FREE, 0, 1'b1, cnt);
        end else begin
          // null frees and arbitrary indexes
          send_word(ACT_FREE, 0, $urandom_range(0, 99) < 60, $urandom_range(0, POOL_BLOCKS - 1));
        end
        sent++;
      end else if (r < 93) begin
        send_word(ACT_RETIRE, 0, 1'b0, 0);
        sent++;
      end else begin
        // hand blocks back while the item budget lasts, then retire
        while (held_blocks.size() > 0 && sent < n) begin
          send_word(ACT_FREE, 0, 1'b1, held_blocks.pop_back());
          sent++;
        end
        send_word(ACT_RETIRE, 0, 1'b0, 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    idle_pct = 10;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(ACT_ALLOC, 0, 1'b0, 0);       // nothing to allocate
    send_word(ACT_FREE, 0, 1'b0, 0);        // null free
    send_word(ACT_FREE, 0, 1'b1, 0);        // block never grown
    send_word(ACT_RETIRE, 0, 1'b0, 0);      // retire of an empty pool
    send_word(ACT_GROW, 0, 1'b0, 0);
    send_word(ACT_GROW, 3, 1'b0, 0);
    send_word(ACT_ALLOC, 0, 1'b0, 0);
    send_word(ACT_ALLOC, 0, 1'b0, 0);
    send_word(ACT_FREE, 0, 1'b1, 5);        // beyond the grown range
    send_word(ACT_FREE, 0, 1'b1, 2);
    send_word(ACT_RETIRE, 0, 1'b0, 0);      // one block still out
    send_word(ACT_FREE, 0, 1'b1, 1);
    send_word(ACT_FREE, 0, 1'b1, 1);        // nothing outstanding
    send_word(ACT_RETIRE, 0, 1'b0, 0);
    send_word(ACT_GROW, POOL_BLOCKS, 1'b0, 0);
    send_word(ACT_GROW, 1, 1'b0, 0);        // pool already full
    send_word(ACT_ALLOC, 0, 1'b0, 0);
    send_word(ACT_ALLOC, 0, 1'b0, 0);
    send_word(ACT_FREE, 0, 1'b1, POOL_BLOCKS - 2);
    send_word(ACT_FREE, 0, 1'b1, POOL_BLOCKS - 1);
    send_word(ACT_RETIRE, 0, 1'b0, 0);
    send_word(ACT_GROW, 1000, 1'b0, 0);
    send_word(ACT_GROW, 100, 1'b0, 0);      // only part of it fits
    send_word(ACT_RETIRE, 0, 1'b0, 0);

    rand_items(345);
    idle_pct = 46;
    rand_items(345);
    idle_pct = 0;
    rand_items(345);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/flbp_pkg.sv
rtl/flbp_ram.sv
rtl/flbp_ctrl.sv
rtl/flbp_dp.sv
rtl/free_list_block_pool_core.sv
tb/pool_result_checker.sv
tb/tb_free_list_block_pool_core.sv
